>>> rtl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Types, codes and constants shared by the serial byte stream framer.
// ----------------------------------------------------------------------------
package sbf_pkg;

	localparam int DELIM_MAX_DEF       = 4;
	localparam int MAX_FRAME_LIMIT_DEF = 65536;
	localparam int MAX_RESULTS         = 8;
	localparam int MIN_FRAME           = 128;

	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	localparam logic [1:0] FUNC_DATA  = 2'd0;
	localparam logic [1:0] FUNC_FLUSH = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_DELIM = 2'd2;
	localparam logic [1:0] MODE_FIXED = 2'd3;

	localparam logic [2:0] CFG_FRAME_MODE = 3'd0;
	localparam logic [2:0] CFG_DELIM_BYTES = 3'd1;
	localparam logic [2:0] CFG_DELIM_LEN  = 3'd2;
	localparam logic [2:0] CFG_FIXED_LEN  = 3'd3;
	localparam logic [2:0] CFG_MAX_FRAME  = 3'd4;
	localparam logic [2:0] CFG_TRIM_CR    = 3'd5;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} sbf_cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       frame_end;
		logic       run_last;
	} sbf_res_t;

endpackage

>>> rtl/serial_byte_stream_framer.sv
// ----------------------------------------------------------------------------
// serial_byte_stream_framer
// Cuts a received byte stream into frames: raw, line, delimiter or fixed.
// ----------------------------------------------------------------------------
// Usage:
// cmd carries one word per handshake: a data byte, a flush or a clear.
// res streams the frame words: payload bytes (has_byte) and a closing word
// (frame_end), with run_last on the last word caused by one cmd word.
// The cfg port writes the six framing registers; each write drops the
// pending frame. Write only while the block is idle.
// Latency: a cmd word is processed in its accept cycle and its first result
// is presented on res in the next cycle.
// Throughput: one cmd word per cycle while res_ready is high and each word
// yields at most one result; a word that yields more results holds the
// result buffer, and cmd_ready returns as its last result is taken.
// Stall: when res_ready is low the buffered results hold and cmd_ready
// stays low until the buffer drains down to its last word.
// Reset: arst_n clears the pending frame and the result buffer and loads
// line mode on LF, trim_cr set, fixed length 16 and a 4096 byte maximum.
// ----------------------------------------------------------------------------
module serial_byte_stream_framer
	import sbf_pkg::*;
#(
	parameter int DELIM_MAX       = DELIM_MAX_DEF,
	parameter int MAX_FRAME_LIMIT = MAX_FRAME_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  sbf_cmd_t    cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output sbf_res_t    res
);

	localparam int HD   = DELIM_MAX + 1;
	localparam int CW   = $clog2(HD + 1);
	localparam int HIW  = (HD > 1) ? $clog2(HD) : 1;
	localparam int TW   = $clog2(HD + 3);
	localparam int FWL  = $clog2(MAX_FRAME_LIMIT + 2);
	localparam int FW   = (FWL > 17) ? FWL : 17;
	localparam int RW   = $clog2(MAX_RESULTS + 1);
	localparam int IW   = $clog2(MAX_RESULTS);

	logic [1:0]    frame_mode_q;
	logic [31:0]   delim_bytes_q;
	logic [2:0]    delim_len_q;
	logic [16:0]   fixed_len_q;
	logic [16:0]   max_frame_q;
	logic          trim_cr_q;

	logic [FW-1:0] fc_q;
	logic [CW-1:0] hc_q;
	logic [7:0]    hb_q [HD];

	sbf_res_t      res_q [MAX_RESULTS];
	logic [RW-1:0] res_cnt_q;
	logic [IW-1:0] res_idx_q;

	logic [FW-1:0] em, ef, mfb_w, fl_w, nf;
	logic          custom;
	logic [CW-1:0] dlen, steady, nc;
	logic [7:0]    dbyte [DELIM_MAX];
	logic [7:0]    nb [HD];
	logic [7:0]    src [HD];
	logic          hit;
	logic          accept, res_last;

	logic          do_close, do_drain, end_f, extra_f;
	logic [CW-1:0] close_n, p_n, hc_d;
	logic [FW-1:0] fc_d;
	logic [7:0]    hb_d [HD];
	logic [TW-1:0] tot;
	logic [RW-1:0] cnt_d;
	sbf_res_t      res_d [MAX_RESULTS];

	assign accept   = cmd_valid && cmd_ready;
	assign res_last = ({1'b0, res_idx_q} + RW'(1)) == res_cnt_q;
	assign cmd_ready = (res_cnt_q == '0) || (res_ready && res_last);
	assign res_valid = (res_cnt_q != '0);

	always_comb begin
		res = res_q[res_idx_q];
		res.run_last = res_last;
	end

	always_comb begin
		mfb_w = FW'(max_frame_q);
		fl_w  = FW'(fixed_len_q);
		if (mfb_w < FW'(MIN_FRAME)) begin
			em = FW'(MIN_FRAME);
		end else if (mfb_w > FW'(MAX_FRAME_LIMIT)) begin
			em = FW'(MAX_FRAME_LIMIT);
		end else begin
			em = mfb_w;
		end
		if (fl_w == '0) begin
			ef = FW'(1);
		end else if (fl_w > em) begin
			ef = em;
		end else begin
			ef = fl_w;
		end
		custom = (frame_mode_q == MODE_DELIM) && (delim_len_q != 3'd0);
		if (!custom) begin
			dlen = CW'(1);
		end else if (int'(delim_len_q) > DELIM_MAX) begin
			dlen = CW'(DELIM_MAX);
		end else begin
			dlen = CW'(delim_len_q);
		end
		for (int k = 0; k < DELIM_MAX; k++) begin
			if (!custom) begin
				dbyte[k] = LF_BYTE;
			end else if (k < 4) begin
				dbyte[k] = delim_bytes_q[8 * (k % 4) +: 8];
			end else begin
				dbyte[k] = 8'h00;
			end
		end
		if (frame_mode_q == MODE_FIXED) begin
			steady = CW'(trim_cr_q);
		end else begin
			steady = dlen - CW'(1) + CW'(trim_cr_q);
		end
	end

	always_comb begin
		logic [CW-1:0] ix;
		for (int i = 0; i < HD; i++) begin
			if (hc_q == CW'(HD)) begin
				nb[i] = (i == HD - 1) ? cmd.data_byte : hb_q[(i + 1) % HD];
			end else begin
				nb[i] = (CW'(i) == hc_q) ? cmd.data_byte : hb_q[i];
			end
		end
		nc = (hc_q == CW'(HD)) ? CW'(HD) : hc_q + CW'(1);
		nf = fc_q + FW'(1);
		hit = (nc >= dlen);
		for (int k = 0; k < DELIM_MAX; k++) begin
			ix = nc - dlen + CW'(k);
			if (CW'(k) < dlen && hit) begin
				if (nb[ix[HIW-1:0]] != dbyte[k]) begin
					hit = 1'b0;
				end
			end
		end
	end

	always_comb begin
		logic [CW:0]   j;
		logic [CW-1:0] cm1;
		do_close = 1'b0;
		do_drain = 1'b0;
		extra_f  = 1'b0;
		end_f    = 1'b0;
		close_n  = '0;
		p_n      = '0;
		src      = nb;
		hc_d     = hc_q;
		fc_d     = fc_q;
		hb_d     = hb_q;
		case (cmd.func)
			FUNC_DATA: begin
				if (frame_mode_q == MODE_RAW) begin
					src[0]   = cmd.data_byte;
					do_close = 1'b1;
					close_n  = CW'(1);
				end else if (frame_mode_q == MODE_FIXED) begin
					if (nf >= ef) begin
						do_close = 1'b1;
						close_n  = nc;
						hc_d     = '0;
						fc_d     = '0;
					end else begin
						do_drain = 1'b1;
					end
				end else if (hit) begin
					do_close = 1'b1;
					close_n  = nc - dlen;
					hc_d     = '0;
					fc_d     = '0;
				end else if (nf > em) begin
					do_close = 1'b1;
					close_n  = nc - CW'(1);
					extra_f  = (steady == '0);
					hb_d[0]  = cmd.data_byte;
					hc_d     = (steady == '0) ? CW'(0) : CW'(1);
					fc_d     = FW'(1);
				end else begin
					do_drain = 1'b1;
				end
			end
			FUNC_FLUSH: begin
				src = hb_q;
				if (frame_mode_q != MODE_RAW && fc_q != '0) begin
					do_close = 1'b1;
					close_n  = hc_q;
				end
				hc_d = '0;
				fc_d = '0;
			end
			FUNC_CLEAR: begin
				hc_d = '0;
				fc_d = '0;
			end
			default: begin
			end
		endcase

		cm1 = close_n - CW'(1);
		if (do_close) begin
			end_f = 1'b1;
			if (trim_cr_q && close_n != '0 && src[cm1[HIW-1:0]] == CR_BYTE) begin
				p_n = cm1;
			end else begin
				p_n = close_n;
			end
		end else if (do_drain) begin
			p_n  = (nc > steady) ? nc - steady : '0;
			hc_d = nc - p_n;
			fc_d = nf;
			for (int i = 0; i < HD; i++) begin
				j = (CW + 1)'(i) + {1'b0, p_n};
				hb_d[i] = (j < (CW + 1)'(HD)) ? nb[j[HIW-1:0]] : 8'h00;
			end
		end

		tot = TW'(p_n) + TW'(end_f) + TW'(extra_f);
		cnt_d = (int'(tot) > MAX_RESULTS) ? RW'(MAX_RESULTS) : RW'(tot);
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_d[i] = '0;
			if (i < int'(p_n)) begin
				res_d[i].out_byte = src[i % HD];
				res_d[i].has_byte = 1'b1;
			end else if (i == int'(p_n) && end_f) begin
				res_d[i].frame_end = 1'b1;
			end else if (i == int'(p_n) + int'(end_f) && extra_f) begin
				res_d[i].out_byte = cmd.data_byte;
				res_d[i].has_byte = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q  <= MODE_LINE;
			delim_bytes_q <= 32'd10;
			delim_len_q   <= 3'd1;
			fixed_len_q   <= 17'd16;
			max_frame_q   <= 17'd4096;
			trim_cr_q     <= 1'b1;
			fc_q          <= '0;
			hc_q          <= '0;
			res_cnt_q     <= '0;
			res_idx_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_MODE:  frame_mode_q  <= cfg_data[1:0];
					CFG_DELIM_BYTES: delim_bytes_q <= cfg_data;
					CFG_DELIM_LEN:   delim_len_q   <= cfg_data[2:0];
					CFG_FIXED_LEN:   fixed_len_q   <= cfg_data[16:0];
					CFG_MAX_FRAME:   max_frame_q   <= cfg_data[16:0];
					CFG_TRIM_CR:     trim_cr_q     <= cfg_data[0];
					default: begin
					end
				endcase
				if (cfg_index <= CFG_TRIM_CR) begin
					fc_q <= '0;
					hc_q <= '0;
				end
			end else if (accept) begin
				fc_q <= fc_d;
				hc_q <= hc_d;
			end
			if (accept) begin
				res_cnt_q <= cnt_d;
				res_idx_q <= '0;
			end else if (res_valid && res_ready) begin
				if (res_last) begin
					res_cnt_q <= '0;
					res_idx_q <= '0;
				end else begin
					res_idx_q <= res_idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hb_q  <= hb_d;
			res_q <= res_d;
		end
	end

endmodule
